/* rtl/gfsc_pkg.sv */
// shared constants and types of the grid frequency stability check
package gfsc_pkg;

    // analyser tick rate in hertz and the frequency held after reset
    localparam int unsigned TICK_RATE = 16000;
    localparam int unsigned RESET_HZ  = 40;

    // whole-hertz bits of a frequency, enough for the tick rate itself
    localparam int unsigned HZ_BITS = 14;

    // default parameter values
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF  = 8;

    // field widths of the beats
    localparam int unsigned COUNT_FIELD_BITS = 16;
    localparam int unsigned FREQ_BITS        = 22;
    localparam int unsigned ROC_BITS         = 24;
    localparam int unsigned IN_DATA_BITS     = 16;
    localparam int unsigned OUT_DATA_BITS    = 48;
    localparam int unsigned OUT_PAD_BITS     = OUT_DATA_BITS - FREQ_BITS - ROC_BITS;
    localparam int unsigned OUT_USER_BITS    = 2;

    // configuration registers
    localparam int unsigned REG_BITS       = 10;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FREQ_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROC_THRESHOLD  = 2'd1;
    localparam logic [REG_BITS-1:0] FREQ_THRESHOLD_RST = 10'd50;
    localparam logic [REG_BITS-1:0] ROC_THRESHOLD_RST  = 10'd10;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_DIV2 = 6'b010000,
        S_LOAD = 6'b100000
    } state_t;

endpackage

/* rtl/grid_frequency_stability_check.sv */
// mains frequency and rate-of-change monitor with bit-serial arithmetic
//
// channel   dir  handshake            content
// s_*       in   s_tvalid/s_tready    tdata[15:0] period_count
// m_*       out  m_tvalid/m_tready    tdata[21:0] frequency, [45:22] roc, [47:46] zero
//                                     tuser[0] unstable, tuser[1] bad_count
// cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value (always ready)
//
// an item runs from accept to the output register through one-bit-per-cycle shift
// registers, with NW = 14 + FRAC_BITS and XW = 3*NW - FRAC_BITS + 1: a restoring
// divider for the NW-bit frequency, a shift-add multiplier used twice, and a
// restoring divider for the XW-bit rate quotient. a zero count skips all of it
// and goes straight to the load state.
// rst_n clears the sequencer and the output valid and sets the thresholds and the old frequency to their reset values.
// a new beat is taken while a result waits in the output register; a finished
// result waits in the load state until that register is free.
module grid_frequency_stability_check #(
    parameter int unsigned COUNT_BITS = gfsc_pkg::COUNT_BITS_DEF,
    parameter int unsigned FRAC_BITS  = gfsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [gfsc_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [15:0] period_count
    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gfsc_pkg::OUT_DATA_BITS-1:0]    m_tdata,   // frequency, roc, zero pad
    output logic [gfsc_pkg::OUT_USER_BITS-1:0]    m_tuser,   // unstable, bad_count
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gfsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gfsc_pkg::REG_BITS-1:0]         cfg_data
);

    // raw frequency width, product width, multiplicand width, rate dividend width
    localparam int unsigned NW = gfsc_pkg::HZ_BITS + FRAC_BITS;
    localparam int unsigned PW = 3 * NW;
    localparam int unsigned AW = 2 * NW;
    localparam int unsigned XW = PW - FRAC_BITS + 1;
    localparam int unsigned CW = $clog2(XW);

    localparam logic [NW-1:0] TICK_DIVIDEND = NW'(gfsc_pkg::TICK_RATE) << FRAC_BITS;
    localparam logic [NW-1:0] PREV_RST      = NW'(gfsc_pkg::RESET_HZ) << FRAC_BITS;
    localparam logic [CW-1:0] NW_LAST       = CW'(NW - 1);
    localparam logic [CW-1:0] XW_LAST       = CW'(XW - 1);

    // control state
    gfsc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [NW-1:0]    prev_freq_reg, prev_freq_next;
    logic [gfsc_pkg::REG_BITS-1:0] freq_thr_reg, freq_thr_next;
    logic [gfsc_pkg::REG_BITS-1:0] roc_thr_reg, roc_thr_next;

    // datapath
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] rem1_reg, rem1_next;
    logic [NW-1:0]         quo1_reg, quo1_next;    // dividend bits out, quotient bits in
    logic [PW-1:0]         prod_reg, prod_next;    // product high, multiplier bits low
    logic [AW-1:0]         mcand_reg, mcand_next;
    logic [NW:0]           sum_reg, sum_next;
    logic [NW:0]           rem2_reg, rem2_next;
    logic [XW-1:0]         dq_reg, dq_next;        // rate dividend out, quotient in
    logic                  bad_reg, bad_next;
    logic [gfsc_pkg::FREQ_BITS-1:0] freq_out_reg, freq_out_next;
    logic [gfsc_pkg::ROC_BITS-1:0]  roc_out_reg, roc_out_next;
    logic                  unstable_reg, unstable_next;
    logic                  bad_out_reg, bad_out_next;

    // one step of each serial unit
    logic [COUNT_BITS:0]   div1_trial;
    logic [COUNT_BITS:0]   div1_sub;
    logic                  div1_ge;
    logic [COUNT_BITS-1:0] div1_rem;
    logic [NW-1:0]         div1_quo;
    logic [AW:0]           mul_upper;
    logic [PW-1:0]         mul_prod;
    logic [NW+1:0]         div2_trial;
    logic [NW+1:0]         div2_sub;
    logic                  div2_ge;
    logic [NW:0]           div2_rem;
    logic [XW-1:0]         div2_quo;

    // end-of-item evaluation
    logic [COUNT_BITS-1:0] in_count;
    logic [NW-1:0]         freq_diff;
    logic [XW-1:0]         rate_q;
    logic                  rate_over;
    logic                  freq_low;
    logic                  rate_high;
    logic                  load_out;

    assign in_count = COUNT_BITS'(s_tdata[gfsc_pkg::COUNT_FIELD_BITS-1:0]);

    // restoring divider for the frequency: one quotient bit a cycle
    assign div1_trial = {rem1_reg, quo1_reg[NW-1]};
    assign div1_sub   = div1_trial - {1'b0, count_reg};
    assign div1_ge    = (div1_trial >= {1'b0, count_reg});
    assign div1_rem   = div1_ge ? div1_sub[COUNT_BITS-1:0] : div1_trial[COUNT_BITS-1:0];
    assign div1_quo   = {quo1_reg[NW-2:0], div1_ge};

    // shift-add multiplier, low multiplier bit first
    assign mul_upper = {1'b0, prod_reg[PW-1:NW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mul_prod  = {mul_upper, prod_reg[NW-1:1]};

    // restoring divider for the rate, divisor is the frequency sum
    assign div2_trial = {rem2_reg, dq_reg[XW-1]};
    assign div2_sub   = div2_trial - {1'b0, sum_reg};
    assign div2_ge    = (div2_trial >= {1'b0, sum_reg});
    assign div2_rem   = div2_ge ? div2_sub[NW:0] : div2_trial[NW:0];
    assign div2_quo   = {dq_reg[XW-2:0], div2_ge};

    // absolute difference of new and old frequency
    assign freq_diff = (quo1_reg >= prev_freq_reg) ? (quo1_reg - prev_freq_reg)
                                                   : (prev_freq_reg - quo1_reg);

    // both frequencies zero: the division ran by zero, rate is zero
    assign rate_q    = (sum_reg == '0) ? '0 : dq_reg;
    assign rate_over = |rate_q[XW-1:gfsc_pkg::ROC_BITS];
    assign freq_low  = (quo1_reg < (NW'(freq_thr_reg) << FRAC_BITS));
    assign rate_high = (rate_q > (XW'(roc_thr_reg) << FRAC_BITS));

    assign load_out = (state_reg == gfsc_pkg::S_LOAD) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev_freq_next = prev_freq_reg;
        count_next     = count_reg;
        rem1_next      = rem1_reg;
        quo1_next      = quo1_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        sum_next       = sum_reg;
        rem2_next      = rem2_reg;
        dq_next        = dq_reg;
        bad_next       = bad_reg;
        freq_out_next  = freq_out_reg;
        roc_out_next   = roc_out_reg;
        unstable_next  = unstable_reg;
        bad_out_next   = bad_out_reg;

        unique case (state_reg)
            gfsc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    count_next = in_count;
                    rem1_next  = '0;
                    quo1_next  = TICK_DIVIDEND;
                    cnt_next   = NW_LAST;
                    if (in_count == '0)
                    begin
                        // bad count goes straight to the load state, old frequency untouched
                        bad_next   = 1'b1;
                        state_next = gfsc_pkg::S_LOAD;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = gfsc_pkg::S_DIV1;
                    end
                end
            end
            gfsc_pkg::S_DIV1:
            begin
                rem1_next = div1_rem;
                quo1_next = div1_quo;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // new frequency times old frequency
                    prod_next  = {{AW{1'b0}}, div1_quo};
                    mcand_next = AW'(prev_freq_reg);
                    cnt_next   = NW_LAST;
                    state_next = gfsc_pkg::S_MUL1;
                end
            end
            gfsc_pkg::S_MUL1:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // then times the difference
                    mcand_next = mul_prod[AW-1:0];
                    prod_next  = {{AW{1'b0}}, freq_diff};
                    sum_next   = {1'b0, quo1_reg} + {1'b0, prev_freq_reg};
                    cnt_next   = NW_LAST;
                    state_next = gfsc_pkg::S_MUL2;
                end
            end
            gfsc_pkg::S_MUL2:
            begin
                prod_next = mul_prod;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // doubled product with the fraction bits dropped
                    dq_next    = mul_prod[PW-1:FRAC_BITS-1];
                    rem2_next  = '0;
                    cnt_next   = XW_LAST;
                    state_next = gfsc_pkg::S_DIV2;
                end
            end
            gfsc_pkg::S_DIV2:
            begin
                rem2_next = div2_rem;
                dq_next   = div2_quo;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = gfsc_pkg::S_LOAD;
                end
            end
            gfsc_pkg::S_LOAD:
            begin
                if (load_out)
                begin
                    if (bad_reg)
                    begin
                        freq_out_next = '0;
                        roc_out_next  = '0;
                        unstable_next = 1'b1;
                        bad_out_next  = 1'b1;
                    end
                    else
                    begin
                        freq_out_next  = gfsc_pkg::FREQ_BITS'(quo1_reg);
                        roc_out_next   = rate_over ? '1 : rate_q[gfsc_pkg::ROC_BITS-1:0];
                        unstable_next  = freq_low || rate_high;
                        bad_out_next   = 1'b0;
                        prev_freq_next = quo1_reg;
                    end
                    state_next = gfsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gfsc_pkg::S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // register writes, unknown indexes ignored
    always_comb
    begin
        freq_thr_next = freq_thr_reg;
        roc_thr_next  = roc_thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gfsc_pkg::CFG_FREQ_THRESHOLD: freq_thr_next = cfg_data;
                gfsc_pkg::CFG_ROC_THRESHOLD:  roc_thr_next  = cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfsc_pkg::S_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            prev_freq_reg <= PREV_RST;
            freq_thr_reg  <= gfsc_pkg::FREQ_THRESHOLD_RST;
            roc_thr_reg   <= gfsc_pkg::ROC_THRESHOLD_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            prev_freq_reg <= prev_freq_next;
            freq_thr_reg  <= freq_thr_next;
            roc_thr_reg   <= roc_thr_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        rem1_reg     <= rem1_next;
        quo1_reg     <= quo1_next;
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        sum_reg      <= sum_next;
        rem2_reg     <= rem2_next;
        dq_reg       <= dq_next;
        bad_reg      <= bad_next;
        freq_out_reg <= freq_out_next;
        roc_out_reg  <= roc_out_next;
        unstable_reg <= unstable_next;
        bad_out_reg  <= bad_out_next;
    end

    assign s_tready  = (state_reg == gfsc_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{gfsc_pkg::OUT_PAD_BITS{1'b0}}, roc_out_reg, freq_out_reg};
    assign m_tuser   = {bad_out_reg, unstable_reg};

    // one item in flight: an accepted beat closes the input until it is done
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while an item is in progress");

    // a bad count result carries zero fields and the unstable flag
    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |->
            (m_tdata[gfsc_pkg::FREQ_BITS+gfsc_pkg::ROC_BITS-1:0] == '0 && m_tuser[0]))
        else $error("bad count result with nonzero fields or stable flag");

    // the old frequency moves only when a good result is loaded
    a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(prev_freq_reg) |-> $past(load_out && !bad_reg))
        else $error("old frequency changed outside a result load");

endmodule

/* test/tb_top.sv */
// self-checking testbench for the grid frequency stability check
module tb_top;

    localparam int unsigned FREQ_BITS        = gfsc_pkg::FREQ_BITS;
    localparam int unsigned ROC_BITS         = gfsc_pkg::ROC_BITS;
    localparam int unsigned REG_BITS         = gfsc_pkg::REG_BITS;
    localparam int unsigned CFG_INDEX_BITS   = gfsc_pkg::CFG_INDEX_BITS;
    localparam int unsigned COUNT_FIELD_BITS = gfsc_pkg::COUNT_FIELD_BITS;
    localparam int unsigned IN_DATA_BITS     = gfsc_pkg::IN_DATA_BITS;
    localparam int unsigned OUT_DATA_BITS    = gfsc_pkg::OUT_DATA_BITS;
    localparam int unsigned OUT_USER_BITS    = gfsc_pkg::OUT_USER_BITS;
    localparam int unsigned OUT_PAD_BITS     = gfsc_pkg::OUT_PAD_BITS;

    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned FRAC           = gfsc_pkg::FRAC_BITS_DEF;
    localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
    // settle time after the last result, well past the time one item takes
    localparam int unsigned DRAIN_CYCLES   = 300;
    // long receiver hold-off, longer than one item takes, so the block backs up
    localparam int unsigned HOLD_CYCLES    = 1500;
    localparam int unsigned GAP_PCT        = 14;
    localparam int unsigned RANDOM_BLOCKS  = 6;
    localparam int unsigned BLOCK_ITEMS    = 200;
    localparam logic [REG_BITS-1:0] REG_TOP = 10'd999;
    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [ROC_BITS-1:0] ROC_SAT = '1;

    // one result beat as the block should produce it
    typedef struct packed {
        logic [FREQ_BITS-1:0] frequency;
        logic [ROC_BITS-1:0]  roc;
        logic                 unstable;
        logic                 bad_count;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [IN_DATA_BITS-1:0]     s_tdata   = '0;    // [15:0] period_count
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]    m_tdata;           // [21:0] frequency, [45:22] roc, pad
    logic [OUT_USER_BITS-1:0]    m_tuser;           // [0] unstable, [1] bad_count
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [REG_BITS-1:0]         cfg_data  = '0;

    // predictor copy of the block state and thresholds
    logic [FREQ_BITS-1:0] model_prev_freq  = FREQ_BITS'(gfsc_pkg::RESET_HZ << FRAC);
    logic [REG_BITS-1:0]  model_freq_limit = gfsc_pkg::FREQ_THRESHOLD_RST;
    logic [REG_BITS-1:0]  model_roc_limit  = gfsc_pkg::ROC_THRESHOLD_RST;

    reading_t pending_readings[$];

    int unsigned send_gap_pct  = GAP_PCT;
    int unsigned ready_gap_pct = GAP_PCT;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned walk_count    = 320;

    int unsigned counts_sent      = 0;
    int unsigned zero_counts      = 0;
    int unsigned reg_writes       = 0;
    int unsigned readings_checked = 0;
    int unsigned saturated_seen   = 0;
    int unsigned unstable_seen    = 0;
    int unsigned input_stalls     = 0;
    int unsigned mismatches       = 0;

    grid_frequency_stability_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // frequency is 16000 / count in q.8, rate is the exact scaled difference,
    // truncated, with the threshold test on the unsaturated rate
    function automatic reading_t predict_reading(input logic [COUNT_FIELD_BITS-1:0] count);
        reading_t             r;
        logic [63:0]          full_scale;
        logic [FREQ_BITS-1:0] f_new;
        logic [FREQ_BITS-1:0] f_old;
        logic [FREQ_BITS-1:0] delta;
        logic [127:0]         rate;
        r = '0;
        // zero count: flagged bad, old frequency kept
        if (count == '0)
        begin
            r.unstable  = 1'b1;
            r.bad_count = 1'b1;
            return r;
        end
        full_scale = 64'(gfsc_pkg::TICK_RATE) << FRAC;
        f_new = FREQ_BITS'(full_scale / 64'(count));
        f_old = model_prev_freq;
        delta = (f_new >= f_old) ? f_new - f_old : f_old - f_new;
        // the sum is never zero here, the smallest raw frequency is 62
        rate = (128'(f_new) * 128'(f_old) * 128'(delta) * 128'd2)
             / (128'(64'(f_new) + 64'(f_old)) << FRAC);
        r.frequency = f_new;
        r.roc       = (rate > 128'(ROC_SAT)) ? ROC_SAT : rate[ROC_BITS-1:0];
        r.unstable  = (64'(f_new) < (64'(model_freq_limit) << FRAC))
                   || (rate > (128'(model_roc_limit) << FRAC));
        model_prev_freq = f_new;
        return r;
    endfunction

    // one period count beat; valid stays high after the handshake so the next
    // call can follow back to back, idle gaps drop it
    task automatic send_count(input logic [COUNT_FIELD_BITS-1:0] count);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= count;
        do
            @(posedge clk);
        while (!s_tready);
        pending_readings.push_back(predict_reading(count));
        counts_sent++;
        if (count == '0)
            zero_counts++;
    endtask

    // sender pause until every expected result is back, the block is then idle
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [REG_BITS-1:0] value, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == gfsc_pkg::CFG_FREQ_THRESHOLD)
            model_freq_limit = value;
        else if (index == gfsc_pkg::CFG_ROC_THRESHOLD)
            model_roc_limit = value;
        if (last)
            cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_limits(input logic [REG_BITS-1:0] freq_hz,
                              input logic [REG_BITS-1:0] roc_units);
        write_reg(gfsc_pkg::CFG_FREQ_THRESHOLD, freq_hz, 1'b0);
        write_reg(gfsc_pkg::CFG_ROC_THRESHOLD, roc_units, 1'b1);
    endtask

    // mostly a mains-like random walk near 50 hz, the rest spread over the field
    function automatic logic [COUNT_FIELD_BITS-1:0] pick_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            walk_count = walk_count + $urandom_range(8) - 4;
            if (walk_count < 250 || walk_count > 420)
                walk_count = $urandom_range(300, 340);
            return COUNT_FIELD_BITS'(walk_count);
        end
        else if (pick < 65)
            return COUNT_FIELD_BITS'($urandom_range(260, 400));
        else if (pick < 75)
            return COUNT_FIELD_BITS'($urandom_range(1, 255));
        else if (pick < 89)
            return COUNT_FIELD_BITS'($urandom);
        else if (pick < 94)
            return '0;
        else if (pick < 97)
            return '1;
        return COUNT_FIELD_BITS'($urandom_range(1, 8));
    endfunction

    // reset thresholds and the 40 hz start value, edge counts, zero counts
    task automatic test_directed_counts();
        logic [COUNT_FIELD_BITS-1:0] counts[$];
        counts = '{16'd320, 16'd320, 16'd400, 16'd0, 16'd0, 16'd400, 16'd1, 16'd2,
                   16'd1, 16'hFFFF, 16'hFFFE, 16'h8000, 16'd16000, 16'd0, 16'd324,
                   16'd316, 16'd327, 16'd320, 16'd256, 16'd384, 16'h5555, 16'hAAAA,
                   16'd3, 16'd320};
        foreach (counts[i])
            send_count(counts[i]);
        settle();
    endtask

    // both thresholds at their extremes and then at 50 and 1, writes to spare indexes ignored
    task automatic test_threshold_extremes();
        logic [REG_BITS-1:0] freq_set[$];
        logic [REG_BITS-1:0] roc_set[$];
        freq_set = '{10'd0, REG_TOP, REG_TOP, 10'd0, 10'd50};
        roc_set  = '{10'd0, REG_TOP, 10'd0, REG_TOP, 10'd1};
        foreach (freq_set[i])
        begin
            if (i == 1)
            begin
                // spare writes follow the real ones without dropping valid
                write_reg(gfsc_pkg::CFG_FREQ_THRESHOLD, freq_set[i], 1'b0);
                write_reg(gfsc_pkg::CFG_ROC_THRESHOLD, roc_set[i], 1'b0);
                write_reg(CFG_SPARE_LO, 10'h3FF, 1'b0);
                write_reg(CFG_SPARE_HI, 10'h000, 1'b1);
            end
            else
                set_limits(freq_set[i], roc_set[i]);
            repeat (6)
                send_count(pick_count());
            settle();
        end
    endtask

    // receiver holds off long while the sender keeps offering beats
    task automatic test_output_backpressure();
        hold_request  = 1'b1;
        send_gap_pct  = 0;
        repeat (12)
            send_count(COUNT_FIELD_BITS'($urandom_range(280, 360)));
        settle();
        send_gap_pct  = GAP_PCT;
    endtask

    // random blocks, each under fresh thresholds, one without any idling
    task automatic test_random_mains();
        logic [REG_BITS-1:0] freq_hz;
        logic [REG_BITS-1:0] roc_units;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            freq_hz   = $urandom_range(1) ? REG_BITS'($urandom_range(40, 60))
                                          : REG_BITS'($urandom_range(0, 999));
            roc_units = $urandom_range(1) ? REG_BITS'($urandom_range(0, 30))
                                          : REG_BITS'($urandom_range(0, 999));
            set_limits(freq_hz, roc_units);
            send_gap_pct  = (blk == 3) ? 0 : GAP_PCT;
            ready_gap_pct = (blk == 3) ? 0 : GAP_PCT;
            repeat (BLOCK_ITEMS)
                send_count(pick_count());
            settle();
        end
        send_gap_pct  = GAP_PCT;
        ready_gap_pct = GAP_PCT;
    endtask

    // result side ready, with random stalls and the occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= ready_gap_pct);
    end

    // every accepted result beat against the oldest expected reading
    always @(posedge clk)
    begin : check_results
        reading_t seen;
        reading_t want;
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.frequency = m_tdata[FREQ_BITS-1:0];
            seen.roc       = m_tdata[FREQ_BITS +: ROC_BITS];
            seen.unstable  = m_tuser[0];
            seen.bad_count = m_tuser[1];
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: freq %0d roc %0d unstable %b bad %b",
                             seen.frequency, seen.roc, seen.unstable, seen.bad_count);
            end
            else
            begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (want.roc == ROC_SAT)
                    saturated_seen++;
                if (want.unstable)
                    unstable_seen++;
                if (seen != want || m_tdata[FREQ_BITS+ROC_BITS +: OUT_PAD_BITS] != '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: want freq %0d roc %0d unstable %b bad %b",
                                 readings_checked, want.frequency, want.roc,
                                 want.unstable, want.bad_count);
                        $display("    got freq %0d roc %0d unstable %b bad %b pad %b",
                                 seen.frequency, seen.roc, seen.unstable, seen.bad_count,
                                 m_tdata[FREQ_BITS+ROC_BITS +: OUT_PAD_BITS]);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_counts();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_mains();
        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("sent %0d period counts (%0d zero), made %0d register writes, checked %0d results",
                 counts_sent, zero_counts, reg_writes, readings_checked);
        $display("%0d unstable and %0d saturated rates expected, input stalled %0d cycles",
                 unstable_seen, saturated_seen, input_stalls);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d results outstanding", pending_readings.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/gfsc_pkg.sv
rtl/grid_frequency_stability_check.sv
test/tb_top.sv
